FILE: design/cld_pkg.sv
// ----------------------------------------------------------------------------
// cld_pkg
// shared constants and types for the crlf line deframer
// ----------------------------------------------------------------------------
`default_nettype none

package cld_pkg;

  localparam int BUFFER_SIZE_DEF = 64;
  localparam int BYTE_W          = 8;

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  // request from the line control to the drain unit
  typedef struct packed {
    logic go;
    logic empty;
  } cld_start_t;

endpackage

`default_nettype wire

FILE: design/crlf_line_deframer_unit.sv
// ----------------------------------------------------------------------------
// crlf_line_deframer_unit
// collects received bytes into lines ended by cr lf and emits each line
// byte by byte
// ----------------------------------------------------------------------------
// A data byte that follows a held CR stalls the input for the ST_WR2 state,
// since both the CR and the byte are written through the single write port
// of the line store. When CR LF completes a line the input is stalled while
// the line is read out of the store: each byte passes through the read data
// register of the store into the output register, one per cycle when the
// output is not stalled. A line holds at most BUFFER_SIZE-1 bytes. An empty
// line gives one transfer flagged empty with length 0. A line that would
// overflow the store is dropped and everything up to the next CR LF is
// ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module crlf_line_deframer_unit #(
  parameter int BUFFER_SIZE = cld_pkg::BUFFER_SIZE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic [cld_pkg::BYTE_W-1:0]     in_rx_byte,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic [cld_pkg::BYTE_W-1:0]     out_line_byte,
  output      logic [$clog2(BUFFER_SIZE)-1:0] out_line_length,
  output      logic                           out_is_empty,
  output      logic                           out_is_last
);

  import cld_pkg::*;

  localparam int DEPTH = BUFFER_SIZE - 1;
  localparam int CW    = $clog2(BUFFER_SIZE);
  localparam int AW    = $clog2(DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WR2   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic              cr_r, cr_nxt;
  logic              disc_r, disc_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;

  logic              is_cr, is_lf, full;
  logic              do_store;
  logic [BYTE_W-1:0] st_byte;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  cld_start_t        start;
  logic              busy;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;

  assign is_cr    = (in_rx_byte == CHAR_CR);
  assign is_lf    = (in_rx_byte == CHAR_LF);
  assign full     = (fill_r >= CW'(DEPTH));
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    cr_nxt      = cr_r;
    disc_nxt    = disc_r;
    byte_nxt    = byte_r;
    do_store    = 1'b0;
    st_byte     = in_rx_byte;
    start.go    = 1'b0;
    start.empty = (fill_r == '0);
    wr_en       = 1'b0;
    wr_addr     = fill_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (disc_r) begin
            if (cr_r && is_lf) begin
              fill_nxt = '0;
              cr_nxt   = 1'b0;
              disc_nxt = 1'b0;
            end else begin
              cr_nxt = is_cr;
            end
          end else if (cr_r && is_lf) begin
            start.go  = 1'b1;
            fill_nxt  = '0;
            cr_nxt    = 1'b0;
            state_nxt = ST_DRAIN;
          end else if (cr_r) begin
            // held cr becomes data; the new byte is lost if the cr overflows
            do_store = 1'b1;
            st_byte  = CHAR_CR;
            cr_nxt   = 1'b0;
            if (!full) begin
              if (is_cr) begin
                cr_nxt = 1'b1;
              end else if (!is_lf) begin
                byte_nxt  = in_rx_byte;
                state_nxt = ST_WR2;
              end
            end
          end else if (is_cr) begin
            cr_nxt = 1'b1;
          end else if (!is_lf) begin
            do_store = 1'b1;
          end
        end
      end
      ST_WR2: begin
        do_store  = 1'b1;
        st_byte   = byte_r;
        state_nxt = ST_IDLE;
      end
      ST_DRAIN: begin
        if (!busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (do_store) begin
      if (full) begin
        fill_nxt = '0;
        cr_nxt   = 1'b0;
        disc_nxt = 1'b1;
      end else begin
        wr_en    = 1'b1;
        fill_nxt = fill_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      cr_r    <= 1'b0;
      disc_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      cr_r    <= cr_nxt;
      disc_r  <= disc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  cld_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (st_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cld_drain #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_drain (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .start_len       (fill_r),
    .busy            (busy),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_line_byte   (out_line_byte),
    .out_line_length (out_line_length),
    .out_is_empty    (out_is_empty),
    .out_is_last     (out_is_last)
  );

endmodule

`default_nettype wire

FILE: design/cld_ram.sv
// ----------------------------------------------------------------------------
// cld_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module cld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/cld_drain.sv
// ----------------------------------------------------------------------------
// cld_drain
// reads a completed line out of the line store and presents it one byte per
// transfer through an output register
// ----------------------------------------------------------------------------
`default_nettype none

module cld_drain #(
  parameter int BUFFER_SIZE = cld_pkg::BUFFER_SIZE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire cld_pkg::cld_start_t            start,
  input  wire logic [$clog2(BUFFER_SIZE)-1:0] start_len,
  output      logic                           busy,
  output      logic                           rd_en,
  output      logic [$clog2(BUFFER_SIZE-1)-1:0] rd_addr,
  input  wire logic [cld_pkg::BYTE_W-1:0]     rd_data,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic [cld_pkg::BYTE_W-1:0]     out_line_byte,
  output      logic [$clog2(BUFFER_SIZE)-1:0] out_line_length,
  output      logic                           out_is_empty,
  output      logic                           out_is_last
);

  import cld_pkg::*;

  localparam int CW = $clog2(BUFFER_SIZE);
  localparam int AW = $clog2(BUFFER_SIZE - 1);

  logic          act_r, act_nxt;
  logic          empty_r, empty_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          rd_last_r, rd_last_nxt;
  logic [CW-1:0] rd_len_r, rd_len_nxt;

  logic              oval_r, oval_nxt;
  logic [BYTE_W-1:0] obyte_r, obyte_nxt;
  logic [CW-1:0]     olen_r, olen_nxt;
  logic              oempty_r, oempty_nxt;
  logic              olast_r, olast_nxt;

  logic out_free, load, emp_load, issue, issue_last;

  assign out_free   = !oval_r || !out_stall;
  assign load       = rd_pend_r && out_free;
  assign emp_load   = empty_r && !rd_pend_r && out_free;
  assign issue      = act_r && (!rd_pend_r || load);
  assign issue_last = (cnt_r == len_r - CW'(1));

  assign busy    = act_r || empty_r;
  assign rd_en   = issue;
  assign rd_addr = cnt_r[AW-1:0];

  always_comb begin
    act_nxt     = act_r;
    empty_nxt   = empty_r;
    cnt_nxt     = cnt_r;
    len_nxt     = len_r;
    rd_pend_nxt = rd_pend_r;
    rd_last_nxt = rd_last_r;
    rd_len_nxt  = rd_len_r;
    oval_nxt    = oval_r;
    obyte_nxt   = obyte_r;
    olen_nxt    = olen_r;
    oempty_nxt  = oempty_r;
    olast_nxt   = olast_r;

    if (start.go) begin
      act_nxt   = !start.empty;
      empty_nxt = start.empty;
      cnt_nxt   = '0;
      len_nxt   = start_len;
    end

    // output register
    if (load) begin
      oval_nxt    = 1'b1;
      obyte_nxt   = rd_data;
      olen_nxt    = rd_len_r;
      oempty_nxt  = 1'b0;
      olast_nxt   = rd_last_r;
      rd_pend_nxt = 1'b0;
    end else if (emp_load) begin
      oval_nxt   = 1'b1;
      obyte_nxt  = '0;
      olen_nxt   = '0;
      oempty_nxt = 1'b1;
      olast_nxt  = 1'b1;
      empty_nxt  = 1'b0;
    end else if (!out_stall) begin
      oval_nxt = 1'b0;
    end

    // read issue, the read data register acts as the second stage
    if (issue) begin
      rd_pend_nxt = 1'b1;
      rd_last_nxt = issue_last;
      rd_len_nxt  = len_r;
      cnt_nxt     = cnt_r + CW'(1);
      if (issue_last) begin
        act_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= 1'b0;
      empty_r   <= 1'b0;
      rd_pend_r <= 1'b0;
      oval_r    <= 1'b0;
    end else begin
      act_r     <= act_nxt;
      empty_r   <= empty_nxt;
      rd_pend_r <= rd_pend_nxt;
      oval_r    <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    len_r     <= len_nxt;
    rd_last_r <= rd_last_nxt;
    rd_len_r  <= rd_len_nxt;
    obyte_r   <= obyte_nxt;
    olen_r    <= olen_nxt;
    oempty_r  <= oempty_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_valid       = oval_r;
  assign out_line_byte   = obyte_r;
  assign out_line_length = olen_r;
  assign out_is_empty    = oempty_r;
  assign out_is_last     = olast_r;

endmodule

`default_nettype wire

FILE: design/cld_checker.sv
// ----------------------------------------------------------------------------
// cld_checker
// port level checks for the crlf line deframer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module cld_checker #(
  parameter int BUFFER_SIZE = cld_pkg::BUFFER_SIZE_DEF
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [cld_pkg::BYTE_W-1:0]     out_line_byte,
  input wire logic [$clog2(BUFFER_SIZE)-1:0] out_line_length,
  input wire logic                           out_is_empty,
  input wire logic                           out_is_last
);

  import cld_pkg::*;

  // an empty line is a single zero transfer
  a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |->
      out_is_last && out_line_length == '0 && out_line_byte == '0)
    else $error("empty line transfer malformed");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_empty |-> out_line_length != '0)
    else $error("non-empty line with zero length");

  // the bytes of one line follow without a gap and carry the same length
  a_line_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_is_last |=>
      out_valid && !out_is_empty && out_line_length == $past(out_line_length))
    else $error("line run broken");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_line_byte) && $stable(out_is_last))
    else $error("stalled transfer changed");

endmodule

bind crlf_line_deframer_unit cld_checker #(
  .BUFFER_SIZE (BUFFER_SIZE)
) u_cld_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_line_byte   (out_line_byte),
  .out_line_length (out_line_length),
  .out_is_empty    (out_is_empty),
  .out_is_last     (out_is_last)
);

`default_nettype wire

FILE: test/crlf_line_deframer_unit_test.sv
// ----------------------------------------------------------------------------
// crlf_line_deframer_unit_test
// self-checking bench for the crlf line deframer: directed and random byte
// streams go in, and every line transfer that comes out is compared against
// a line-by-line prediction of the deframing, including overflow and recovery
// ----------------------------------------------------------------------------
`default_nettype none

module crlf_line_deframer_unit_test;

  import cld_pkg::*;

  localparam int LINE_MAX = BUFFER_SIZE_DEF - 1;
  localparam int LEN_W    = $clog2(BUFFER_SIZE_DEF);

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              empty;
    logic              last;
  } line_beat_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [BYTE_W-1:0] out_line_byte;
  logic [LEN_W-1:0]  out_line_length;
  logic              out_is_empty;
  logic              out_is_last;

  // predicted deframer state
  logic [BYTE_W-1:0] line_copy [LINE_MAX];
  logic [LEN_W-1:0]  fill      = '0;
  logic              cr_held   = 1'b0;
  logic              dropping  = 1'b0;

  line_beat_t line_bytes_due[$];

  // no random idling on either side while set
  logic calm = 1'b0;

  int mismatch_count = 0;
  int bytes_sent     = 0;
  int transfers_seen = 0;
  int lines_done     = 0;
  int empty_lines    = 0;
  int longest_line   = 0;

  crlf_line_deframer_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_line_byte   (out_line_byte),
    .out_line_length (out_line_length),
    .out_is_empty    (out_is_empty),
    .out_is_last     (out_is_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 7);
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic void keep_byte(input logic [BYTE_W-1:0] b);
    if (fill < LEN_W'(LINE_MAX)) begin
      line_copy[fill] = b;
      fill++;
    end else begin
      // overflow: line thrown away, wait for the next cr lf
      fill     = '0;
      cr_held  = 1'b0;
      dropping = 1'b1;
    end
  endfunction

  function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
    line_beat_t beat;
    if (dropping) begin
      if (cr_held && b == CHAR_LF) begin
        fill     = '0;
        cr_held  = 1'b0;
        dropping = 1'b0;
      end else begin
        cr_held = (b == CHAR_CR);
      end
      return;
    end
    if (cr_held) begin
      if (b == CHAR_LF) begin
        if (fill == 0) begin
          beat = '{data: '0, len: '0, empty: 1'b1, last: 1'b1};
          line_bytes_due.push_back(beat);
        end else begin
          for (int k = 0; k < int'(fill); k++) begin
            beat = '{data: line_copy[k], len: fill, empty: 1'b0,
                     last: (k + 1 == int'(fill))};
            line_bytes_due.push_back(beat);
          end
        end
        fill    = '0;
        cr_held = 1'b0;
        return;
      end
      // held cr turns out to be data
      keep_byte(CHAR_CR);
      cr_held = 1'b0;
      if (dropping) return;
    end
    if (b == CHAR_CR) cr_held = 1'b1;
    else if (b != CHAR_LF) keep_byte(b);
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic end_line();
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
  endtask

  function automatic logic [BYTE_W-1:0] rand_data_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255)); while (b == CHAR_CR || b == CHAR_LF);
    return b;
  endfunction

  // any byte, with cr and lf made more likely than plain chance
  function automatic logic [BYTE_W-1:0] rand_rx_byte(input int ctrl_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < ctrl_pct / 2) return CHAR_CR;
    if (roll < ctrl_pct) return CHAR_LF;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic send_data_run(input int n);
    repeat (n) send_byte(rand_data_byte());
  endtask

  always @(posedge clk) begin : check_lines
    line_beat_t due;
    if (rst_n && out_valid && !out_stall) begin
      transfers_seen++;
      if (out_is_last) lines_done++;
      if (out_is_empty) empty_lines++;
      if (int'(out_line_length) > longest_line) longest_line = int'(out_line_length);
      if (line_bytes_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected line transfer, byte %02h", out_line_byte));
      end else begin
        due = line_bytes_due.pop_front();
        if (out_line_byte !== due.data)
          flag_mismatch($sformatf("line_byte %02h, expected %02h", out_line_byte, due.data));
        if (out_line_length !== due.len)
          flag_mismatch($sformatf("line_length %0d, expected %0d", out_line_length, due.len));
        if (out_is_empty !== due.empty)
          flag_mismatch($sformatf("is_empty %b, expected %b", out_is_empty, due.empty));
        if (out_is_last !== due.last)
          flag_mismatch($sformatf("is_last %b, expected %b", out_is_last, due.last));
      end
    end
  end

  // cr lf with nothing stored, and a bare lf that must vanish
  task automatic test_empty_lines();
    end_line();
    send_byte(CHAR_LF);
    end_line();
  endtask

  // a cr not followed by lf is kept as data, also at the end of a line
  task automatic test_held_cr();
    send_byte(8'h41);
    send_byte(CHAR_CR);
    send_byte(8'h42);
    send_byte(CHAR_CR);
    end_line();
  endtask

  task automatic test_byte_extremes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(CHAR_LF);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h0C);
    send_byte(8'h0E);
    end_line();
  endtask

  task automatic test_random_lines();
    int sent;
    int len;
    int kind;
    sent = 0;
    while (sent < 8) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        len = $urandom_range(0, 4);
        repeat (len) send_byte(rand_rx_byte(10));
        end_line();
        sent += len + 2;
      end else begin
        len = $urandom_range(1, 3);
        repeat (len) send_byte(rand_rx_byte(50));
        sent += len;
      end
    end
    // close whatever the noise left open
    end_line();
    end_line();
  endtask

  // longest line, with no idling on either side until it has drained
  task automatic test_full_line();
    calm = 1'b1;
    send_data_run(LINE_MAX);
    end_line();
    wait (line_bytes_due.size() == 0);
    calm = 1'b0;
  endtask

  task automatic test_overflow();
    // held cr fills the last entry and the byte after it is lost
    send_data_run(LINE_MAX - 1);
    send_byte(CHAR_CR);
    send_byte(8'h5A);
    // a cr followed by other data must not end the discard
    send_byte(CHAR_CR);
    send_byte(8'h79);
    end_line();
    send_byte(8'h6B);
    end_line();
  endtask

  initial begin : run_tests
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_lines();
    test_held_cr();
    test_byte_extremes();
    test_random_lines();
    test_full_line();
    test_overflow();

    @(negedge clk);
    in_valid <= 1'b0;
    for (int n = 0; n < 20000 && line_bytes_due.size() != 0; n++) @(posedge clk);
    repeat (BUFFER_SIZE_DEF + 8) @(posedge clk);
    if (line_bytes_due.size() != 0)
      flag_mismatch($sformatf("%0d line transfers never arrived", line_bytes_due.size()));

    $display("covered %0d received bytes and %0d line transfers: %0d lines, %0d empty,",
             bytes_sent, transfers_seen, lines_done, empty_lines);
    $display("longest line %0d bytes, overflow and discard recovery included", longest_line);
    if (mismatch_count == 0) begin
      $display("crlf_line_deframer_unit_test: PASS");
    end else begin
      $display("crlf_line_deframer_unit_test: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("run timed out");
    $display("crlf_line_deframer_unit_test: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
